@@ src/gds_pkg.sv @@
// Shared types and constants for the grid decomposition search block.
// Used by the divider, datapath, controller and top level; no dependencies.
`default_nettype none
package gds_pkg;

    localparam int EXT_W  = 11;
    localparam int NP_W   = 17;
    localparam int FAC_W  = 10;
    localparam int CNT_W  = 11;
    localparam int DEN_W  = 10;
    localparam int PROD_W = 22;
    localparam int SUM_W  = 25;
    localparam int SURF_W = 23;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;
    localparam int EXT_LIMIT = 2047;

    localparam logic [SURF_W-1:0] SURF_MAX = {SURF_W{1'b1}};

    localparam logic [2:0] SEL_NP_X   = 3'd0;
    localparam logic [2:0] SEL_CEIL_A = 3'd1;
    localparam logic [2:0] SEL_Q_Y    = 3'd2;
    localparam logic [2:0] SEL_CEIL_B = 3'd3;
    localparam logic [2:0] SEL_CEIL_C = 3'd4;

    typedef struct packed {
        logic       load;
        logic       start;
        logic [2:0] sel;
        logic       next_x;
        logic       latch_q;
        logic       latch_a;
        logic       next_y;
        logic       latch_z;
        logic       latch_b;
        logic       latch_c;
        logic       mul;
        logic       sum;
        logic       emit;
    } cmd_t;

    typedef struct packed {
        logic x_end;
        logic y_end;
        logic div_done;
        logic rem_zero;
        logic z_ok;
        logic out_free;
    } stat_t;

endpackage
`default_nettype wire

@@ src/gds_div.sv @@
// Restoring divider, one quotient bit per cycle, for the search datapath.
// Depends on gds_pkg for operand widths.
`default_nettype none
module gds_div (
    input  wire                      aclk,
    input  wire                      aresetn,
    input  wire                      start,
    input  wire [gds_pkg::NP_W-1:0]  num,
    input  wire [gds_pkg::DEN_W-1:0] den,
    output logic                     done,
    output logic [gds_pkg::NP_W-1:0] quo,
    output logic [gds_pkg::DEN_W-1:0] rem
);
    import gds_pkg::*;

    localparam int CW = $clog2(NP_W + 1);
    localparam logic [CW-1:0] STEPS = CW'(NP_W);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [NP_W-1:0]   quo_reg, quo_next;
    logic [DEN_W-1:0]  rem_reg, rem_next;
    logic [DEN_W-1:0]  den_reg, den_next;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;

    assign trial = {rem_reg, quo_reg[NP_W-1]};
    assign diff  = trial - {1'b0, den_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = STEPS;
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end else if (busy_reg) begin
            if (trial >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NP_W-2:0], 1'b1};
            end else begin
                rem_next = trial[DEN_W-1:0];
                quo_next = {quo_reg[NP_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule
`default_nettype wire

@@ src/gds_dp.sv @@
// Search datapath: request registers, loop counters, shared divider,
// surface products, best-split tracking and the result register.
// Depends on gds_pkg and gds_div.
`default_nettype none
module gds_dp #(
    parameter int MAX_EXTENT = 1024
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  gds_pkg::cmd_t                cmd,
    output gds_pkg::stat_t               stat,
    input  wire [gds_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    output logic [gds_pkg::M_DATA_W-1:0] m_tdata,
    output logic [0:0]                   m_tuser
);
    import gds_pkg::*;

    localparam int CLAMP_INT = (MAX_EXTENT > EXT_LIMIT) ? EXT_LIMIT : MAX_EXTENT;
    localparam logic [EXT_W-1:0] EXT_CLAMP = EXT_W'(CLAMP_INT);

    logic [EXT_W-1:0]  ex_reg, ey_reg, ez_reg;
    logic [NP_W-1:0]   np_reg;
    logic [CNT_W-1:0]  x_reg, y_reg;
    logic [NP_W-1:0]   q_reg;
    logic [EXT_W-1:0]  a_reg, b_reg, c_reg;
    logic [FAC_W-1:0]  z_reg;
    logic [PROD_W-1:0] ab_reg, ac_reg, bc_reg;
    logic [SUM_W-1:0]  best_reg;
    logic              have_reg;
    logic [FAC_W-1:0]  bx_reg, by_reg, bz_reg;
    logic              m_valid_reg, m_valid_next;
    logic              found_reg;
    logic [FAC_W-1:0]  px_reg, py_reg, pz_reg;
    logic [SURF_W-1:0] surf_reg;

    logic [EXT_W-1:0]  in_ex, in_ey, in_ez;
    logic [FAC_W-1:0]  xm, ym, zm;
    logic [NP_W-1:0]   div_num;
    logic [DEN_W-1:0]  div_den;
    logic              div_done;
    logic [NP_W-1:0]   div_quo;
    logic [DEN_W-1:0]  div_rem;
    logic [EXT_W:0]    ceil_a, ceil_b, ceil_c;
    logic [SUM_W-1:0]  surf_sum;
    logic              better;

    assign in_ex = (s_tdata[10:0]  > EXT_CLAMP) ? EXT_CLAMP : s_tdata[10:0];
    assign in_ey = (s_tdata[21:11] > EXT_CLAMP) ? EXT_CLAMP : s_tdata[21:11];
    assign in_ez = (s_tdata[32:22] > EXT_CLAMP) ? EXT_CLAMP : s_tdata[32:22];

    assign xm = ex_reg[EXT_W-1:1];
    assign ym = ey_reg[EXT_W-1:1];
    assign zm = ez_reg[EXT_W-1:1];

    assign ceil_a = {1'b0, ex_reg} + {1'b0, x_reg} - 12'd1;
    assign ceil_b = {1'b0, ey_reg} + {1'b0, y_reg} - 12'd1;
    assign ceil_c = {1'b0, ez_reg} + {2'b0, z_reg} - 12'd1;

    always_comb begin
        unique case (cmd.sel)
            SEL_NP_X: begin
                div_num = np_reg;
                div_den = x_reg[DEN_W-1:0];
            end
            SEL_CEIL_A: begin
                div_num = NP_W'(ceil_a);
                div_den = x_reg[DEN_W-1:0];
            end
            SEL_Q_Y: begin
                div_num = q_reg;
                div_den = y_reg[DEN_W-1:0];
            end
            SEL_CEIL_B: begin
                div_num = NP_W'(ceil_b);
                div_den = y_reg[DEN_W-1:0];
            end
            SEL_CEIL_C: begin
                div_num = NP_W'(ceil_c);
                div_den = z_reg;
            end
            default: begin
                div_num = np_reg;
                div_den = x_reg[DEN_W-1:0];
            end
        endcase
    end

    gds_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    assign surf_sum = {({2'b0, ab_reg} + {2'b0, ac_reg} + {2'b0, bc_reg}), 1'b0};
    assign better = !have_reg || (surf_sum < best_reg);

    assign stat.x_end    = (np_reg == '0) || (x_reg > {1'b0, xm});
    assign stat.y_end    = (y_reg > {1'b0, ym}) || ({6'b0, y_reg} > q_reg);
    assign stat.div_done = div_done;
    assign stat.rem_zero = (div_rem == '0);
    assign stat.z_ok     = (div_rem == '0) && (div_quo <= {7'b0, zm});
    assign stat.out_free = !m_valid_reg || m_tready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            have_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd.load) begin
                have_reg <= 1'b0;
            end else if (cmd.sum) begin
                have_reg <= 1'b1;
            end
        end
        if (cmd.load) begin
            ex_reg   <= in_ex;
            ey_reg   <= in_ey;
            ez_reg   <= in_ez;
            np_reg   <= s_tdata[49:33];
            x_reg    <= CNT_W'(1);
            best_reg <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            bz_reg   <= '0;
        end
        if (cmd.next_x) begin
            x_reg <= x_reg + CNT_W'(1);
        end
        if (cmd.latch_q) begin
            q_reg <= div_quo;
        end
        if (cmd.latch_a) begin
            a_reg <= div_quo[EXT_W-1:0];
            y_reg <= CNT_W'(1);
        end
        if (cmd.next_y) begin
            y_reg <= y_reg + CNT_W'(1);
        end
        if (cmd.latch_z) begin
            z_reg <= div_quo[FAC_W-1:0];
        end
        if (cmd.latch_b) begin
            b_reg <= div_quo[EXT_W-1:0];
        end
        if (cmd.latch_c) begin
            c_reg <= div_quo[EXT_W-1:0];
        end
        if (cmd.mul) begin
            ab_reg <= PROD_W'(a_reg) * PROD_W'(b_reg);
            ac_reg <= PROD_W'(a_reg) * PROD_W'(c_reg);
            bc_reg <= PROD_W'(b_reg) * PROD_W'(c_reg);
        end
        if (cmd.sum && better) begin
            best_reg <= surf_sum;
            bx_reg   <= x_reg[FAC_W-1:0];
            by_reg   <= y_reg[FAC_W-1:0];
            bz_reg   <= z_reg;
        end
        if (cmd.emit) begin
            found_reg <= have_reg;
            px_reg    <= bx_reg;
            py_reg    <= by_reg;
            pz_reg    <= bz_reg;
            surf_reg  <= (best_reg > {2'b0, SURF_MAX}) ? SURF_MAX : best_reg[SURF_W-1:0];
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tuser[0] = found_reg;
    assign m_tdata    = {3'b0, surf_reg, pz_reg, py_reg, px_reg};

endmodule
`default_nettype wire

@@ src/gds_ctrl.sv @@
// Search sequencer: walks x, then y, issues divider jobs and datapath strobes.
// Depends on gds_pkg for the command and status structs.
`default_nettype none
module gds_ctrl (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_tvalid,
    output logic           s_tready,
    input  gds_pkg::stat_t stat,
    output gds_pkg::cmd_t  cmd
);
    import gds_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_X_CHK = 4'd1;
    localparam logic [3:0] ST_X_DIV = 4'd2;
    localparam logic [3:0] ST_A_DIV = 4'd3;
    localparam logic [3:0] ST_Y_CHK = 4'd4;
    localparam logic [3:0] ST_Y_DIV = 4'd5;
    localparam logic [3:0] ST_B_DIV = 4'd6;
    localparam logic [3:0] ST_C_DIV = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_SUM   = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    logic [3:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.sel    = SEL_NP_X;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_X_CHK;
                end
            end
            ST_X_CHK: begin
                if (stat.x_end) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_NP_X;
                    state_next = ST_X_DIV;
                end
            end
            ST_X_DIV: begin
                if (stat.div_done) begin
                    if (stat.rem_zero) begin
                        cmd.latch_q = 1'b1;
                        cmd.start   = 1'b1;
                        cmd.sel     = SEL_CEIL_A;
                        state_next  = ST_A_DIV;
                    end else begin
                        cmd.next_x = 1'b1;
                        state_next = ST_X_CHK;
                    end
                end
            end
            ST_A_DIV: begin
                if (stat.div_done) begin
                    cmd.latch_a = 1'b1;
                    state_next  = ST_Y_CHK;
                end
            end
            ST_Y_CHK: begin
                if (stat.y_end) begin
                    cmd.next_x = 1'b1;
                    state_next = ST_X_CHK;
                end else begin
                    cmd.start  = 1'b1;
                    cmd.sel    = SEL_Q_Y;
                    state_next = ST_Y_DIV;
                end
            end
            ST_Y_DIV: begin
                if (stat.div_done) begin
                    if (stat.z_ok) begin
                        cmd.latch_z = 1'b1;
                        cmd.start   = 1'b1;
                        cmd.sel     = SEL_CEIL_B;
                        state_next  = ST_B_DIV;
                    end else begin
                        cmd.next_y = 1'b1;
                        state_next = ST_Y_CHK;
                    end
                end
            end
            ST_B_DIV: begin
                if (stat.div_done) begin
                    cmd.latch_b = 1'b1;
                    cmd.start   = 1'b1;
                    cmd.sel     = SEL_CEIL_C;
                    state_next  = ST_C_DIV;
                end
            end
            ST_C_DIV: begin
                if (stat.div_done) begin
                    cmd.latch_c = 1'b1;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                cmd.sum    = 1'b1;
                cmd.next_y = 1'b1;
                state_next = ST_Y_CHK;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule
`default_nettype wire

@@ src/grid_decomposition_search.sv @@
// Top level of the grid decomposition search: sequencer plus datapath.
// Depends on gds_pkg, gds_ctrl, gds_dp (and gds_div below it).
//
// Usage:
//   s_ channel: one word per request, extents and process count.
//   m_ channel: one word per request, best split and its halo surface;
//   m_tuser carries the found flag, and all other fields are zero when clear.
//   Every split x*y*z == proc_count with each factor up to half its extent
//   is scored; the smallest surface wins, first one in x, y, z order on ties.
//   Pace: one shared 17-step divider sets it, one job at a time. Each x up
//   to extent_x/2 costs one divider job; each x dividing proc_count adds a
//   second job plus one job per y up to min(extent_y/2, proc_count/x); each
//   valid split adds two more jobs and the multiply and sum steps. m_tvalid
//   is registered from the emit strobe in the done state after the search.
//   One request is worked at a time; s_tready is high only between requests.
//   The finished word sits in an output register, so a new request is taken
//   while the previous word waits; the search then holds in its last step
//   until m_tready frees the register.
//   Reset: aresetn low for one clock clears the sequencer and m_tvalid.
`default_nettype none
module grid_decomposition_search #(
    parameter int MAX_EXTENT = 1024
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    output logic                         s_tready,
    // [10:0] extent_x, [21:11] extent_y, [32:22] extent_z, [49:33] proc_count
    input  wire [gds_pkg::S_DATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  wire                          m_tready,
    // [9:0] parts_x, [19:10] parts_y, [29:20] parts_z, [52:30] surface
    output logic [gds_pkg::M_DATA_W-1:0] m_tdata,
    // [0] found
    output logic [0:0]                   m_tuser
);
    import gds_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    gds_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    gds_dp #(
        .MAX_EXTENT (MAX_EXTENT)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

`ifndef SYNTHESIS
    a_not_found_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == '0)
        else $error("empty result carries nonzero fields");

    a_found_parts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[9:0] != 10'd0 && m_tdata[19:10] != 10'd0 && m_tdata[29:20] != 10'd0)
        else $error("found split has a zero factor");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while search still running");
`endif

endmodule
`default_nettype wire

@@ tb/testbench.sv @@
// Testbench for grid_decomposition_search: directed table, then random requests.
// Each result word is checked against the table's expected values or a local min-surface split search.
// Depends on gds_pkg and the grid_decomposition_search RTL only.
`timescale 1ns / 1ps
module testbench;

    localparam int MAX_EXTENT   = 1024;
    localparam int N_RANDOM     = 100;
    localparam int LIMIT_CYCLES = 4000000;

    typedef logic [gds_pkg::EXT_W-1:0] ext_t;
    typedef logic [gds_pkg::NP_W-1:0]  np_t;

    typedef struct packed {
        np_t  proc_count;
        ext_t extent_z;
        ext_t extent_y;
        ext_t extent_x;
    } req_t;

    typedef struct packed {
        logic                        found;
        logic [gds_pkg::FAC_W-1:0]   parts_x;
        logic [gds_pkg::FAC_W-1:0]   parts_y;
        logic [gds_pkg::FAC_W-1:0]   parts_z;
        logic [gds_pkg::SURF_W-1:0]  surface;
    } split_t;

    typedef struct {
        int ex;
        int ey;
        int ez;
        int np;
        bit typed;
        bit found;
        int px;
        int py;
        int pz;
        int surf;
    } dir_row_t;

    // ex, ey, ez, np, typed, found, px, py, pz, surface
    dir_row_t dir_rows [21] = '{
        '{1,    1,    1,    1,      1, 0, 0, 0, 0, 0},
        '{2,    2,    2,    1,      1, 1, 1, 1, 1, 24},
        '{2,    2,    2,    0,      1, 0, 0, 0, 0, 0},
        '{3,    3,    3,    1,      1, 1, 1, 1, 1, 54},
        '{2,    2,    2,    2,      1, 0, 0, 0, 0, 0},
        '{12,   12,   12,   2,      1, 1, 1, 1, 2, 576},
        '{1024, 1024, 1024, 1,      1, 1, 1, 1, 1, 6291456},
        '{2047, 2047, 2047, 1,      1, 1, 1, 1, 1, 6291456},
        '{0,    8,    8,    1,      1, 0, 0, 0, 0, 0},
        '{8,    1,    8,    2,      1, 0, 0, 0, 0, 0},
        '{8,    8,    1,    2,      1, 0, 0, 0, 0, 0},
        '{16,   16,   16,   131071, 1, 0, 0, 0, 0, 0},
        '{1024, 1024, 1024, 131071, 0, 0, 0, 0, 0, 0},
        '{1024, 1024, 1024, 65536,  0, 0, 0, 0, 0, 0},
        '{1025, 8,    8,    2,      0, 0, 0, 0, 0, 0},
        '{64,   64,   64,   64,     0, 0, 0, 0, 0, 0},
        '{10,   6,    4,    6,      0, 0, 0, 0, 0, 0},
        '{1365, 682,  1365, 2,      0, 0, 0, 0, 0, 0},
        '{682,  1365, 682,  6,      0, 0, 0, 0, 0, 0},
        '{1024, 4,    4,    512,    0, 0, 0, 0, 0, 0},
        '{30,   20,   10,   60,     0, 0, 0, 0, 0, 0}
    };

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [gds_pkg::S_DATA_W-1:0]   s_tdata  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [gds_pkg::M_DATA_W-1:0]   m_tdata;
    logic [0:0]                     m_tuser;

    split_t pending_splits [$];
    int     fails         = 0;
    int     cycle_count   = 0;
    int     src_idle_pct  = 24;
    int     sink_idle_pct = 52;

    grid_decomposition_search #(
        .MAX_EXTENT(MAX_EXTENT)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser)
    );

    always #5 aclk = ~aclk;

    function automatic split_t best_split(input req_t r);
        int unsigned ex, ey, ez, np, x, y, z, q;
        longint unsigned a, b, c, s, best;
        split_t res;
        ex = (r.extent_x > MAX_EXTENT) ? MAX_EXTENT : r.extent_x;
        ey = (r.extent_y > MAX_EXTENT) ? MAX_EXTENT : r.extent_y;
        ez = (r.extent_z > MAX_EXTENT) ? MAX_EXTENT : r.extent_z;
        np = r.proc_count;
        res = '0;
        best = 0;
        if (np != 0) begin
            for (x = 1; x <= ex / 2; x++) begin
                if (np % x != 0) continue;
                q = np / x;
                for (y = 1; y <= ey / 2; y++) begin
                    if (q % y != 0) continue;
                    z = q / y;
                    if (z < 1 || z > ez / 2) continue;
                    a = (ex + x - 1) / x;
                    b = (ey + y - 1) / y;
                    c = (ez + z - 1) / z;
                    s = 2 * (a * b + a * c + b * c);
                    if (!res.found || s < best) begin
                        res.found   = 1'b1;
                        best        = s;
                        res.parts_x = gds_pkg::FAC_W'(x);
                        res.parts_y = gds_pkg::FAC_W'(y);
                        res.parts_z = gds_pkg::FAC_W'(z);
                    end
                end
            end
        end
        res.surface = (best > gds_pkg::SURF_MAX) ? gds_pkg::SURF_MAX : gds_pkg::SURF_W'(best);
        return res;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int unsigned kind, fx, fy, fz;
        kind = $urandom_range(99);
        r.extent_x = ext_t'($urandom_range(2, 32));
        r.extent_y = ext_t'($urandom_range(2, 32));
        r.extent_z = ext_t'($urandom_range(2, 32));
        if (kind < 70) begin
            fx = $urandom_range(1, r.extent_x / 2);
            fy = $urandom_range(1, r.extent_y / 2);
            fz = $urandom_range(1, r.extent_z / 2);
            r.proc_count = np_t'(fx * fy * fz);
        end else if (kind < 80) begin
            r.proc_count = np_t'($urandom);
        end else if (kind < 90) begin
            case ($urandom_range(2))
                0: r.extent_x = ext_t'($urandom_range(0, 1));
                1: r.extent_y = ext_t'($urandom_range(0, 1));
                default: r.extent_z = ext_t'($urandom_range(0, 1));
            endcase
            r.proc_count = np_t'($urandom_range(0, 64));
        end else begin
            // wide x extent, often past saturation; keep y and z short
            r.extent_x = ext_t'($urandom_range(33, 2047));
            r.extent_y = ext_t'($urandom_range(2, 16));
            r.extent_z = ext_t'($urandom_range(2, 16));
            fx = $urandom_range(1, ((r.extent_x > MAX_EXTENT) ? MAX_EXTENT : r.extent_x) / 2);
            fy = $urandom_range(1, r.extent_y / 2);
            fz = $urandom_range(1, r.extent_z / 2);
            r.proc_count = np_t'(fx * fy * fz);
        end
        return r;
    endfunction

    task automatic send_request(input req_t r, input split_t want);
        @(negedge aclk);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        pending_splits.push_back(want);
        s_tdata  <= gds_pkg::S_DATA_W'(r);
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
    endtask

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge aclk) begin : check_results
        split_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_splits.size() == 0) begin
                $error("result word with no request pending");
                fails++;
            end else begin
                want = pending_splits.pop_front();
                if (m_tuser[0] !== want.found) begin
                    $error("found: expected %0d, got %0d", want.found, m_tuser[0]);
                    fails++;
                end
                if (m_tdata[9:0] !== want.parts_x) begin
                    $error("parts_x: expected %0d, got %0d", want.parts_x, m_tdata[9:0]);
                    fails++;
                end
                if (m_tdata[19:10] !== want.parts_y) begin
                    $error("parts_y: expected %0d, got %0d", want.parts_y, m_tdata[19:10]);
                    fails++;
                end
                if (m_tdata[29:20] !== want.parts_z) begin
                    $error("parts_z: expected %0d, got %0d", want.parts_z, m_tdata[29:20]);
                    fails++;
                end
                if (m_tdata[52:30] !== want.surface) begin
                    $error("surface: expected %0d, got %0d", want.surface, m_tdata[52:30]);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("grid_decomposition_search test failed");
            $finish;
        end
    end

    initial begin : stimulus
        req_t   r;
        split_t w;
        int     i;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        foreach (dir_rows[k]) begin
            r.extent_x   = ext_t'(dir_rows[k].ex);
            r.extent_y   = ext_t'(dir_rows[k].ey);
            r.extent_z   = ext_t'(dir_rows[k].ez);
            r.proc_count = np_t'(dir_rows[k].np);
            if (dir_rows[k].typed) begin
                w.found   = dir_rows[k].found;
                w.parts_x = gds_pkg::FAC_W'(dir_rows[k].px);
                w.parts_y = gds_pkg::FAC_W'(dir_rows[k].py);
                w.parts_z = gds_pkg::FAC_W'(dir_rows[k].pz);
                w.surface = gds_pkg::SURF_W'(dir_rows[k].surf);
            end else begin
                w = best_split(r);
            end
            send_request(r, w);
        end
        for (i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM / 3) begin
                src_idle_pct  = 52;
                sink_idle_pct = 24;
            end else if (i == 2 * N_RANDOM / 3) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end
            r = random_request();
            send_request(r, best_split(r));
        end
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_splits.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);
        if (fails == 0) begin
            $display("grid_decomposition_search test passed");
        end else begin
            $display("grid_decomposition_search test failed");
        end
        $finish;
    end

endmodule
